[hdl/lbs_pkg.sv]
`default_nettype none
package lbs_pkg;

  localparam int BONE_COUNT     = 64;
  localparam int BONE_W         = 6;
  localparam int WORDS_PER_BONE = 12;
  localparam int SLOT_W         = 4;
  localparam int NUM_INF        = 4;
  localparam int DATA_W         = 32;
  localparam int WEIGHT_W       = 16;
  localparam int ID_W           = 8;
  localparam logic [ID_W-1:0] BREAK_ID = 8'hFF;
  localparam logic [17:0] WEIGHT_ONE   = 18'd32768;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_POINT = 2'd1,
    OP_DIR   = 2'd2
  } op_t;

  // one palette word write, broadcast to every bone lane
  typedef struct packed {
    logic                en;
    logic [BONE_W-1:0]   bone;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   value;
  } pal_wr_t;

  // per-lane transform request
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic                point;
    logic [DATA_W-1:0]   x;
    logic [DATA_W-1:0]   y;
    logic [DATA_W-1:0]   z;
  } bone_req_t;

endpackage
`default_nettype wire

[hdl/linear_blend_skinning.sv]
`default_nettype none
// Linear blend skinning engine, up to four bone influences per vertex.
//
// Input: a beat is taken on a rising edge with start high and busy low.
// busy never rises, so one beat can enter every cycle. Operation 0 writes
// one Q16.16 word of the bone palette (64 bones x 12 words); operations
// 1 and 2 skin a vertex as a point or as a direction; code 3 is dropped.
// A palette write is seen by any skin beat that follows it, even the very
// next cycle.
//
// Output: one result beat per skin beat, shown for exactly one cycle with
// out_valid high. Writes give no beat.
// Throughput is one vertex per cycle: each of the four bone lanes holds its
// own copy of the palette split into twelve word memories, so all 48 words
// are fetched in one read, and every multiply stage is fully parallel.
// The receiver cannot stall, so nothing in the pipe ever holds.
//
// Reset (rst_n low, synchronous) clears the valid bits and control registers;
// the palette comes up undefined and must be written before use.
module linear_blend_skinning (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         in_operation,
  input  wire  [5:0]         in_palette_bone,
  input  wire  [3:0]         in_palette_slot,
  input  wire  signed [31:0] in_palette_value,
  input  wire  signed [31:0] in_pos_x,
  input  wire  signed [31:0] in_pos_y,
  input  wire  signed [31:0] in_pos_z,
  input  wire  [31:0]        in_bone_ids,
  input  wire  [15:0]        in_weight_a,
  input  wire  [15:0]        in_weight_b,
  input  wire  [15:0]        in_weight_c,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_no_influence,
  output logic               out_saturated
);

  localparam int NI = lbs_pkg::NUM_INF;
  localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
  localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

  typedef struct packed {
    logic                                 valid;
    logic                                 none;
    logic [NI-1:0]                        used;
    logic [NI-1:0][lbs_pkg::WEIGHT_W-1:0] w;
  } ctl_t;

  logic accept;

  // stage 1: registered input beat
  logic              s1_valid_r;
  logic [1:0]        s1_op_r;
  logic [5:0]        s1_bone_r;
  logic [3:0]        s1_slot_r;
  logic [31:0]       s1_value_r;
  logic [31:0]       s1_x_r, s1_y_r, s1_z_r;
  logic [31:0]       s1_ids_r;
  logic [15:0]       s1_wa_r, s1_wb_r, s1_wc_r;

  logic [17:0]        wsum;
  logic signed [18:0] w_last;
  logic [NI-1:0]      brk;
  ctl_t               ctl1;
  ctl_t               ctl2_r, ctl3_r, ctl4_r;

  lbs_pkg::pal_wr_t   wr;
  lbs_pkg::bone_req_t req [NI];
  logic signed [31:0] bt  [NI][3];
  logic [NI-1:0]      bsat;

  // stage 5: weighted products
  logic               s5_valid_r;
  logic               s5_none_r;
  logic               s5_sat_r;
  logic signed [48:0] wp_r [NI][3];
  logic signed [50:0] acc  [3];
  logic signed [35:0] shf  [3];

  logic signed [31:0] o_r [3];
  logic               o_valid_r;
  logic               o_none_r;
  logic               o_sat_r;
  logic [2:0]         clip;
  logic signed [31:0] clipped [3];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_op_r    <= in_operation;
      s1_bone_r  <= in_palette_bone;
      s1_slot_r  <= in_palette_slot;
      s1_value_r <= in_palette_value;
      s1_x_r     <= in_pos_x;
      s1_y_r     <= in_pos_y;
      s1_z_r     <= in_pos_z;
      s1_ids_r   <= in_bone_ids;
      s1_wa_r    <= in_weight_a;
      s1_wb_r    <= in_weight_b;
      s1_wc_r    <= in_weight_c;
    end
  end

  // palette write goes out in order with the reads, so it is never stale
  assign wr.en    = s1_valid_r && (s1_op_r == lbs_pkg::OP_WRITE) &&
                    (s1_slot_r < lbs_pkg::SLOT_W'(lbs_pkg::WORDS_PER_BONE));
  assign wr.bone  = s1_bone_r;
  assign wr.slot  = s1_slot_r;
  assign wr.value = s1_value_r;

  // Fourth weight is one minus the rest; a bone is used only before the
  // first break id, and the fourth only when its weight is positive.
  always_comb begin
    wsum   = 18'(s1_wa_r) + 18'(s1_wb_r) + 18'(s1_wc_r);
    w_last = $signed({1'b0, lbs_pkg::WEIGHT_ONE}) - $signed({1'b0, wsum});
    for (int i = 0; i < NI; i++) begin
      brk[i] = (s1_ids_r[i*8 +: 8] == lbs_pkg::BREAK_ID);
    end
    ctl1.valid   = 1'b0;
    ctl1.used[0] = !brk[0];
    for (int i = 1; i < NI; i++) begin
      ctl1.used[i] = ctl1.used[i-1] && !brk[i];
    end
    ctl1.used[NI-1] = ctl1.used[NI-1] && (w_last > 19'sd0);
    ctl1.none = brk[0];
    ctl1.w[0] = ctl1.used[0] ? s1_wa_r : '0;
    ctl1.w[1] = ctl1.used[1] ? s1_wb_r : '0;
    ctl1.w[2] = ctl1.used[2] ? s1_wc_r : '0;
    ctl1.w[3] = ctl1.used[3] ? w_last[15:0] : '0;
    unique case (s1_op_r)
      lbs_pkg::OP_POINT, lbs_pkg::OP_DIR: ctl1.valid = s1_valid_r;
      default:                            ctl1.valid = 1'b0;
    endcase
  end

  // advance control alongside the three bone lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl2_r <= ctl1;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_lane
    assign req[i].id    = s1_ids_r[i*8 +: 8];
    assign req[i].point = (s1_op_r == lbs_pkg::OP_POINT);
    assign req[i].x     = s1_x_r;
    assign req[i].y     = s1_y_r;
    assign req[i].z     = s1_z_r;

    lbs_bone u_bone (
      .clk (clk),
      .wr  (wr),
      .req (req[i]),
      .t_x (bt[i][0]),
      .t_y (bt[i][1]),
      .t_z (bt[i][2]),
      .sat (bsat[i])
    );
  end

  // weight each lane result; unused lanes carry weight zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= ctl4_r.valid;
    end
    s5_none_r <= ctl4_r.none;
    s5_sat_r  <= |(bsat & ctl4_r.used);
    for (int i = 0; i < NI; i++) begin
      for (int r = 0; r < 3; r++) begin
        wp_r[i][r] <= bt[i][r] * $signed({1'b0, ctl4_r.w[i]});
      end
    end
  end

  // sum, floor by 15 bits, clip
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 51'(wp_r[0][r]) + 51'(wp_r[1][r]) + 51'(wp_r[2][r])
             + 51'(wp_r[3][r]);
      shf[r] = acc[r][50:15];
      if (shf[r] > S32_MAX) begin
        clipped[r] = 32'sh7FFFFFFF;
        clip[r]    = 1'b1;
      end else if (shf[r] < S32_MIN) begin
        clipped[r] = 32'sh80000000;
        clip[r]    = 1'b1;
      end else begin
        clipped[r] = shf[r][31:0];
        clip[r]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= s5_valid_r;
    end
    o_none_r <= s5_none_r;
    o_sat_r  <= !s5_none_r && (s5_sat_r || (|clip));
    for (int r = 0; r < 3; r++) begin
      o_r[r] <= s5_none_r ? 32'sd0 : clipped[r];
    end
  end

  assign out_valid        = o_valid_r;
  assign out_x            = o_r[0];
  assign out_y            = o_r[1];
  assign out_z            = o_r[2];
  assign out_no_influence = o_none_r;
  assign out_saturated    = o_sat_r;

  // a result beat always traces back to an accepted skin beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept && (in_operation == lbs_pkg::OP_POINT ||
                                   in_operation == lbs_pkg::OP_DIR), 6))
    else $error("result beat without matching skin beat");

  // no influence means a zero vector and no clipping
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_influence |->
      out_x == 32'sd0 && out_y == 32'sd0 && out_z == 32'sd0 && !out_saturated)
    else $error("no-influence beat carries data");

  // palette writes never reach the result channel
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !ctl1.valid)
    else $error("palette write marked as skin beat");

endmodule
`default_nettype wire

[hdl/lbs_bone.sv]
`default_nettype none
module lbs_bone (
  input  wire                          clk,
  input  wire  lbs_pkg::pal_wr_t       wr,
  input  wire  lbs_pkg::bone_req_t     req,
  output logic signed [31:0]           t_x,
  output logic signed [31:0]           t_y,
  output logic signed [31:0]           t_z,
  output logic                         sat
);

  localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
  localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

  logic [31:0]        rd_r    [lbs_pkg::WORDS_PER_BONE];
  logic signed [31:0] vec_r   [3];
  logic               ok_r;
  logic               point_r;
  logic signed [63:0] full    [3][3];
  logic signed [47:0] prod_r  [3][3];
  logic signed [31:0] trans_r [3];
  logic signed [49:0] sum     [3];
  logic signed [31:0] t_r     [3];
  logic [2:0]         sat_r;

  // one 64-entry memory per matrix word; each lane holds its own copy
  for (genvar g = 0; g < lbs_pkg::WORDS_PER_BONE; g++) begin : g_word
    logic [31:0] mem_r [lbs_pkg::BONE_COUNT];
    always_ff @(posedge clk) begin
      if (wr.en && wr.slot == lbs_pkg::SLOT_W'(g)) begin
        mem_r[wr.bone] <= wr.value;
      end
      rd_r[g] <= mem_r[req.id[lbs_pkg::BONE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    vec_r[0] <= $signed(req.x);
    vec_r[1] <= $signed(req.y);
    vec_r[2] <= $signed(req.z);
    ok_r     <= (req.id[lbs_pkg::ID_W-1:lbs_pkg::BONE_W] == '0);
    point_r  <= req.point;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        full[r][c] = $signed(rd_r[r*4+c]) * vec_r[c];
      end
    end
  end

  // floor each product to Q16.16; out-of-range bones read a zero matrix
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= ok_r ? full[r][c][63:16] : 48'sd0;
      end
      trans_r[r] <= (ok_r && point_r) ? $signed(rd_r[r*4+3]) : 32'sd0;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 50'(prod_r[r][0]) + 50'(prod_r[r][1]) + 50'(prod_r[r][2])
             + 50'(trans_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      if (sum[r] > S32_MAX) begin
        t_r[r]   <= 32'sh7FFFFFFF;
        sat_r[r] <= 1'b1;
      end else if (sum[r] < S32_MIN) begin
        t_r[r]   <= 32'sh80000000;
        sat_r[r] <= 1'b1;
      end else begin
        t_r[r]   <= sum[r][31:0];
        sat_r[r] <= 1'b0;
      end
    end
  end

  assign t_x = t_r[0];
  assign t_y = t_r[1];
  assign t_z = t_r[2];
  assign sat = |sat_r;

endmodule
`default_nettype wire
